@@ src/wfd_pkg.sv @@
package wfd_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int ID_W      = 16;
  localparam int WT_W      = 16;
  localparam int TOT_W     = 20;
  localparam int KIND_W    = 3;
  localparam int CNT_OUT_W = 5;
  localparam int CMD_W     = 2;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 1;

  localparam logic [TOT_W-1:0] LIMIT_RESET = '1;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEPART = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

  localparam logic [KIND_W-1:0] EV_DEPARTED  = 3'd0;
  localparam logic [KIND_W-1:0] EV_AUTO_DEP  = 3'd1;
  localparam logic [KIND_W-1:0] EV_EMPTY     = 3'd2;
  localparam logic [KIND_W-1:0] EV_ADDED     = 3'd3;
  localparam logic [KIND_W-1:0] EV_FULL      = 3'd4;
  localparam logic [KIND_W-1:0] EV_FOUND     = 3'd5;
  localparam logic [KIND_W-1:0] EV_NOT_FOUND = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_AUTO_EN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 1'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_EVICT
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [WT_W-1:0] weight;
  } item_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

@@ src/wfd_cell.sv @@
module wfd_cell (
  input  logic              clk,
  input  wfd_pkg::cell_ctl_t ctl,
  input  wfd_pkg::item_t    load_item,
  input  wfd_pkg::item_t    nbr_item,
  output wfd_pkg::item_t    item
);

  wfd_pkg::item_t data_r;
  wfd_pkg::item_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.load) begin
      data_nxt = load_item;
    end else if (ctl.shift) begin
      data_nxt = nbr_item;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign item = data_r;

endmodule

@@ src/weighted_fifo_drop_oldest_unit.sv @@
// Add, depart and full/empty cases answer in the cycle after start; each
// auto-eviction after an add gives a further word from the evict state. Find
// rotates the occupied cells once around and then answers from the output
// registers. One command at a time, taken only while idle; busy
// drops as the last word goes out. Reset (sync, rst_n low): queue empty, total
// zero, auto-dispatch off, limit all ones. The receiver cannot stall.
module weighted_fifo_drop_oldest_unit #(
  parameter int QUEUE_DEPTH = wfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [wfd_pkg::CMD_W-1:0]      in_cmd,
  input  logic [wfd_pkg::ID_W-1:0]       in_item_id,
  input  logic [wfd_pkg::WT_W-1:0]       in_item_weight,
  output logic                           out_strobe,
  output logic [wfd_pkg::KIND_W-1:0]     out_event_kind,
  output logic [wfd_pkg::ID_W-1:0]       out_id,
  output logic [wfd_pkg::WT_W-1:0]       out_weight,
  output logic [wfd_pkg::TOT_W-1:0]      out_total_after,
  output logic [wfd_pkg::CNT_OUT_W-1:0]  out_count_after,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [wfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wfd_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TOT_W = wfd_pkg::TOT_W;

  wfd_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic             auto_en_r;
  logic [TOT_W-1:0] limit_r;
  logic [wfd_pkg::ID_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0] rot_cnt_r, rot_cnt_nxt;
  logic             hit_r, hit_nxt;
  wfd_pkg::item_t   hit_item_r, hit_item_nxt;

  logic                          out_strobe_r, out_strobe_nxt;
  logic [wfd_pkg::KIND_W-1:0]    out_kind_r, out_kind_nxt;
  logic [wfd_pkg::ID_W-1:0]      out_id_r, out_id_nxt;
  logic [wfd_pkg::WT_W-1:0]      out_weight_r, out_weight_nxt;
  logic [TOT_W-1:0]              out_total_r, out_total_nxt;
  logic [wfd_pkg::CNT_OUT_W-1:0] out_count_r, out_count_nxt;
  logic                          out_last_r, out_last_nxt;

  wfd_pkg::item_t cell_q [QUEUE_DEPTH];
  wfd_pkg::item_t head;
  wfd_pkg::item_t in_item;

  logic accept;
  logic load_en, shift_en, rot_en;
  logic [IDX_W-1:0] tail_idx, last_idx;
  logic [TOT_W-1:0] total_add, total_pop;
  logic [CNT_W-1:0] count_inc, count_dec;
  logic add_full, add_evict, evict_more, find_done, find_match;

  assign accept    = start && (state_r == wfd_pkg::S_IDLE);
  assign busy      = (state_r != wfd_pkg::S_IDLE);
  assign head      = cell_q[0];
  assign in_item   = '{id: in_item_id, weight: in_item_weight};
  assign tail_idx  = count_r[IDX_W-1:0];
  assign last_idx  = tail_idx - IDX_W'(1);
  assign count_inc = count_r + CNT_W'(1);
  assign count_dec = count_r - CNT_W'(1);
  assign total_add = total_r + TOT_W'(in_item_weight);
  assign total_pop = total_r - TOT_W'(head.weight);

  assign add_full   = (count_r >= CNT_W'(QUEUE_DEPTH));
  assign add_evict  = auto_en_r && (total_add > limit_r);
  assign evict_more = auto_en_r && (count_dec != '0) && (total_pop > limit_r);
  assign find_done  = (rot_cnt_r == count_dec);
  assign find_match = (head.id == key_r);

  // Row of cells, head in cell 0. Pop shifts toward the head; find rotates
  // the occupied cells so each item passes cell 0 once and ends where it began.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    wfd_pkg::cell_ctl_t ctl;
    wfd_pkg::item_t     nbr;

    assign ctl.load  = load_en && (tail_idx == IDX_W'(i));
    assign ctl.shift = shift_en;

    if (i < QUEUE_DEPTH - 1) begin : g_mid
      assign nbr = (rot_en && (last_idx == IDX_W'(i))) ? cell_q[0] : cell_q[i+1];
    end else begin : g_end
      assign nbr = (rot_en && (last_idx == IDX_W'(i))) ? cell_q[0] : cell_q[i];
    end

    wfd_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .load_item (in_item),
      .nbr_item  (nbr),
      .item      (cell_q[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wfd_pkg::S_IDLE: begin
        if (accept) begin
          if (in_cmd == wfd_pkg::CMD_ADD && !add_full && add_evict) begin
            state_nxt = wfd_pkg::S_EVICT;
          end else if (in_cmd == wfd_pkg::CMD_FIND && count_r != '0) begin
            state_nxt = wfd_pkg::S_FIND;
          end
        end
      end
      wfd_pkg::S_FIND: begin
        if (find_done) begin
          state_nxt = wfd_pkg::S_IDLE;
        end
      end
      wfd_pkg::S_EVICT: begin
        if (!evict_more) begin
          state_nxt = wfd_pkg::S_IDLE;
        end
      end
      default: state_nxt = wfd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt      = count_r;
    total_nxt      = total_r;
    key_nxt        = key_r;
    rot_cnt_nxt    = rot_cnt_r;
    hit_nxt        = hit_r;
    hit_item_nxt   = hit_item_r;
    load_en        = 1'b0;
    shift_en       = 1'b0;
    rot_en         = 1'b0;
    out_strobe_nxt = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_id_nxt     = out_id_r;
    out_weight_nxt = out_weight_r;
    out_last_nxt   = 1'b1;

    unique case (state_r)
      wfd_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            wfd_pkg::CMD_ADD: begin
              out_strobe_nxt = 1'b1;
              out_id_nxt     = in_item_id;
              out_weight_nxt = in_item_weight;
              if (add_full) begin
                out_kind_nxt = wfd_pkg::EV_FULL;
              end else begin
                out_kind_nxt = wfd_pkg::EV_ADDED;
                load_en      = 1'b1;
                count_nxt    = count_inc;
                total_nxt    = total_add;
                out_last_nxt = !add_evict;
              end
            end
            wfd_pkg::CMD_DEPART: begin
              out_strobe_nxt = 1'b1;
              if (count_r == '0) begin
                out_kind_nxt   = wfd_pkg::EV_EMPTY;
                out_id_nxt     = '0;
                out_weight_nxt = '0;
              end else begin
                out_kind_nxt   = wfd_pkg::EV_DEPARTED;
                out_id_nxt     = head.id;
                out_weight_nxt = head.weight;
                shift_en       = 1'b1;
                count_nxt      = count_dec;
                total_nxt      = total_pop;
              end
            end
            wfd_pkg::CMD_FIND: begin
              key_nxt     = in_item_id;
              rot_cnt_nxt = '0;
              hit_nxt     = 1'b0;
              if (count_r == '0) begin
                out_strobe_nxt = 1'b1;
                out_kind_nxt   = wfd_pkg::EV_NOT_FOUND;
                out_id_nxt     = in_item_id;
                out_weight_nxt = '0;
              end
            end
            default: ;
          endcase
        end
      end
      wfd_pkg::S_FIND: begin
        shift_en    = 1'b1;
        rot_en      = 1'b1;
        rot_cnt_nxt = rot_cnt_r + CNT_W'(1);
        if (!hit_r && find_match) begin
          hit_nxt      = 1'b1;
          hit_item_nxt = head;
        end
        if (find_done) begin
          out_strobe_nxt = 1'b1;
          if (hit_r) begin
            out_kind_nxt   = wfd_pkg::EV_FOUND;
            out_id_nxt     = hit_item_r.id;
            out_weight_nxt = hit_item_r.weight;
          end else if (find_match) begin
            out_kind_nxt   = wfd_pkg::EV_FOUND;
            out_id_nxt     = head.id;
            out_weight_nxt = head.weight;
          end else begin
            out_kind_nxt   = wfd_pkg::EV_NOT_FOUND;
            out_id_nxt     = key_r;
            out_weight_nxt = '0;
          end
        end
      end
      wfd_pkg::S_EVICT: begin
        out_strobe_nxt = 1'b1;
        out_kind_nxt   = wfd_pkg::EV_AUTO_DEP;
        out_id_nxt     = head.id;
        out_weight_nxt = head.weight;
        out_last_nxt   = !evict_more;
        shift_en       = 1'b1;
        count_nxt      = count_dec;
        total_nxt      = total_pop;
      end
      default: ;
    endcase

    out_total_nxt = total_nxt;
    out_count_nxt = wfd_pkg::CNT_OUT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wfd_pkg::S_IDLE;
      count_r      <= '0;
      total_r      <= '0;
      auto_en_r    <= 1'b0;
      limit_r      <= wfd_pkg::LIMIT_RESET;
      rot_cnt_r    <= '0;
      hit_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      total_r      <= total_nxt;
      rot_cnt_r    <= rot_cnt_nxt;
      hit_r        <= hit_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          wfd_pkg::REG_AUTO_EN: auto_en_r <= cfg_wdata[0];
          wfd_pkg::REG_LIMIT:   limit_r   <= cfg_wdata[TOT_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    hit_item_r   <= hit_item_nxt;
    out_kind_r   <= out_kind_nxt;
    out_id_r     <= out_id_nxt;
    out_weight_r <= out_weight_nxt;
    out_total_r  <= out_total_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_event_kind  = out_kind_r;
  assign out_id          = out_id_r;
  assign out_weight      = out_weight_r;
  assign out_total_after = out_total_r;
  assign out_count_after = out_count_r;
  assign out_last        = out_last_r;

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |-> !busy)
    else $error("last word out while still busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("item count above queue depth");

  a_quick_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_cmd == wfd_pkg::CMD_ADD || in_cmd == wfd_pkg::CMD_DEPART))
    |=> out_strobe)
    else $error("add or depart gave no word next cycle");

  a_evict_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wfd_pkg::S_EVICT) |=> (out_strobe && out_event_kind == wfd_pkg::EV_AUTO_DEP))
    else $error("eviction cycle gave no auto-depart word");

endmodule

@@ tb/tb_weighted_fifo_drop_oldest_unit.sv @@
`timescale 1ns / 100ps

module tb_weighted_fifo_drop_oldest_unit;
  import wfd_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int PHASE_ITEMS = 48;
  localparam int NUM_PHASES = 8;
  // cmd code with no defined operation; the block must ignore it
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id;
    logic [WT_W-1:0]  weight;
  } fifo_cmd_t;

  typedef struct {
    logic [KIND_W-1:0]    kind;
    logic [ID_W-1:0]      id;
    logic [WT_W-1:0]      weight;
    logic [TOT_W-1:0]     total;
    logic [CNT_OUT_W-1:0] count;
    logic                 last;
  } fifo_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0] in_cmd = CMD_ADD;
  logic [ID_W-1:0] in_item_id = '0;
  logic [WT_W-1:0] in_item_weight = '0;
  logic out_strobe;
  logic [KIND_W-1:0] out_event_kind;
  logic [ID_W-1:0] out_id;
  logic [WT_W-1:0] out_weight;
  logic [TOT_W-1:0] out_total_after;
  logic [CNT_OUT_W-1:0] out_count_after;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_AUTO_EN;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // shadow of the queue and its policy registers
  logic [ID_W-1:0] ring_id [DEPTH];
  logic [WT_W-1:0] ring_wt [DEPTH];
  int ring_head = 0;
  int ring_tail = 0;
  int ring_count = 0;
  logic [TOT_W-1:0] ring_total = '0;
  bit policy_auto = 1'b0;
  logic [TOT_W-1:0] policy_limit = LIMIT_RESET;

  fifo_cmd_t cmd_backlog [$];
  fifo_event_t expected_events [$];
  fifo_event_t want_ev;
  logic [ID_W-1:0] id_pool [8];

  int gap_left = 0;
  int burst_left = 0;
  int items_sent = 0;
  int words_checked = 0;
  int fail_count = 0;
  int kind_seen [8];

  weighted_fifo_drop_oldest_unit #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_cmd(in_cmd),
    .in_item_id(in_item_id),
    .in_item_weight(in_item_weight),
    .out_strobe(out_strobe),
    .out_event_kind(out_event_kind),
    .out_id(out_id),
    .out_weight(out_weight),
    .out_total_after(out_total_after),
    .out_count_after(out_count_after),
    .out_last(out_last),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic fifo_event_t make_event(input logic [KIND_W-1:0] kind,
                                             input logic [ID_W-1:0] id,
                                             input logic [WT_W-1:0] wt);
    fifo_event_t e;
    e.kind = kind;
    e.id = id;
    e.weight = wt;
    e.total = ring_total;
    e.count = CNT_OUT_W'(ring_count);
    e.last = 1'b0;
    return e;
  endfunction

  function automatic void take_head(output logic [ID_W-1:0] id,
                                    output logic [WT_W-1:0] wt);
    id = ring_id[ring_head];
    wt = ring_wt[ring_head];
    ring_head = (ring_head + 1) % DEPTH;
    ring_count--;
    ring_total = ring_total - TOT_W'(wt);
  endfunction

  task automatic predict_fifo_events(input logic [CMD_W-1:0] cmd,
                                     input logic [ID_W-1:0] id,
                                     input logic [WT_W-1:0] wt);
    fifo_event_t evs [$];
    logic [ID_W-1:0] hid;
    logic [WT_W-1:0] hwt;
    int p;
    int i;
    bit hit;
    hit = 1'b0;
    case (cmd)
      CMD_ADD: begin
        if (ring_count >= DEPTH) begin
          evs.push_back(make_event(EV_FULL, id, wt));
        end else begin
          ring_id[ring_tail] = id;
          ring_wt[ring_tail] = wt;
          ring_tail = (ring_tail + 1) % DEPTH;
          ring_count++;
          ring_total = ring_total + TOT_W'(wt);
          evs.push_back(make_event(EV_ADDED, id, wt));
          // drop oldest while over the limit; may take the new item too
          while (policy_auto && ring_count > 0 && ring_total > policy_limit) begin
            take_head(hid, hwt);
            evs.push_back(make_event(EV_AUTO_DEP, hid, hwt));
          end
        end
      end
      CMD_DEPART: begin
        if (ring_count == 0) begin
          evs.push_back(make_event(EV_EMPTY, '0, '0));
        end else begin
          take_head(hid, hwt);
          evs.push_back(make_event(EV_DEPARTED, hid, hwt));
        end
      end
      CMD_FIND: begin
        p = ring_head;
        for (i = 0; i < ring_count && !hit; i++) begin
          if (ring_id[p] == id) hit = 1'b1;
          else p = (p + 1) % DEPTH;
        end
        if (hit) evs.push_back(make_event(EV_FOUND, ring_id[p], ring_wt[p]));
        else evs.push_back(make_event(EV_NOT_FOUND, id, '0));
      end
      default: ;
    endcase
    if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
    foreach (evs[k]) expected_events.push_back(evs[k]);
  endtask

  function automatic int pick_gap();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 0;
      4, 5, 6, 7: return $urandom_range(1, 6);
      default: return $urandom_range(7, 25);
    endcase
  endfunction

  function automatic int pick_burst();
    if ($urandom_range(0, 4) == 0) return $urandom_range(24, 40);
    return $urandom_range(1, 8);
  endfunction

  task automatic present_next();
    fifo_cmd_t c;
    c = cmd_backlog.pop_front();
    in_cmd <= c.cmd;
    in_item_id <= c.id;
    in_item_weight <= c.weight;
  endtask

  // command driver: bursts of words separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else if (start && !busy) begin
      predict_fifo_events(in_cmd, in_item_id, in_item_weight);
      items_sent++;
      if (burst_left > 0 && cmd_backlog.size() > 0) begin
        burst_left--;
        present_next();
      end else begin
        start <= 1'b0;
        gap_left = pick_gap();
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_backlog.size() > 0) begin
        burst_left = pick_burst();
        present_next();
        start <= 1'b1;
      end
    end
  end

  function automatic void cmp_field(input string name, input logic [TOT_W-1:0] want,
                                    input logic [TOT_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // result monitor: every strobed word is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_events.size() == 0) begin
        $error("unexpected result word: kind %0d id %0h", out_event_kind, out_id);
        fail_count++;
      end else begin
        want_ev = expected_events.pop_front();
        cmp_field("event_kind", TOT_W'(want_ev.kind), TOT_W'(out_event_kind));
        cmp_field("out_id", TOT_W'(want_ev.id), TOT_W'(out_id));
        cmp_field("out_weight", TOT_W'(want_ev.weight), TOT_W'(out_weight));
        cmp_field("total_after", want_ev.total, out_total_after);
        cmp_field("count_after", TOT_W'(want_ev.count), TOT_W'(out_count_after));
        cmp_field("last", TOT_W'(want_ev.last), TOT_W'(out_last));
        words_checked++;
        kind_seen[want_ev.kind]++;
      end
    end
  end

  task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                          input logic [WT_W-1:0] wt);
    fifo_cmd_t c;
    c.cmd = cmd;
    c.id = id;
    c.weight = wt;
    cmd_backlog.push_back(c);
  endtask

  function automatic fifo_cmd_t random_item(input int add_pct);
    fifo_cmd_t c;
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) c.cmd = CMD_UNUSED;
    else if (r < 4 + add_pct) c.cmd = CMD_ADD;
    else if (r < 4 + add_pct + (96 - add_pct) / 2) c.cmd = CMD_DEPART;
    else c.cmd = CMD_FIND;
    // mostly reuse a small id set so finds hit and duplicates occur
    if ($urandom_range(0, 9) < 7) c.id = id_pool[$urandom_range(0, 7)];
    else c.id = ID_W'($urandom);
    case ($urandom_range(0, 9))
      0: c.weight = '0;
      1: c.weight = '1;
      2, 3, 4, 5: c.weight = WT_W'($urandom_range(0, 4095));
      default: c.weight = WT_W'($urandom);
    endcase
    return c;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_policy(input bit en, input logic [TOT_W-1:0] lim);
    write_reg(REG_AUTO_EN, CFG_W'(en));
    write_reg(REG_LIMIT, lim);
    policy_auto = en;
    policy_limit = lim;
  endtask

  // idle point: nothing queued, nothing owed, plus room for a silent unused cmd
  task automatic wait_quiet();
    while (cmd_backlog.size() > 0 || start || expected_events.size() > 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    int i;
    int ph;
    int drain;
    int add_pct;
    bit en;
    logic [TOT_W-1:0] lim;
    logic [ID_W-1:0] fill_id;

    id_pool[0] = '0;
    id_pool[1] = '1;
    for (i = 2; i < 8; i++) id_pool[i] = ID_W'($urandom);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty queue cases, field extremes, unused cmd, fill to full
    push_cmd(CMD_DEPART, ID_W'($urandom), WT_W'($urandom));
    push_cmd(CMD_FIND, 16'h1234, WT_W'($urandom));
    push_cmd(CMD_ADD, '0, '0);
    push_cmd(CMD_ADD, '1, '1);
    push_cmd(CMD_FIND, '1, '0);
    push_cmd(CMD_FIND, '0, '1);
    push_cmd(CMD_FIND, 16'h5A5A, WT_W'($urandom));
    push_cmd(CMD_UNUSED, ID_W'($urandom), WT_W'($urandom));
    push_cmd(CMD_DEPART, '0, '0);
    fill_id = '0;
    for (i = 0; i < DEPTH - 1; i++) begin
      fill_id = (i % 3 == 0) ? 16'h0AAA : ID_W'($urandom);
      push_cmd(CMD_ADD, fill_id, WT_W'($urandom_range(1, 16'hFFFF)));
    end
    push_cmd(CMD_ADD, 16'hBEEF, 16'h8001);
    push_cmd(CMD_FIND, fill_id, '0);
    wait_quiet();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin en = 1'b1; lim = '0; add_pct = 60; end
        1: begin en = 1'b0; lim = '1; add_pct = 75; end
        2: begin en = 1'b1; lim = '1; add_pct = 50; end
        3: begin en = 1'b1; lim = TOT_W'($urandom_range(60000, 300000)); add_pct = 55; end
        4: begin en = 1'b1; lim = TOT_W'($urandom_range(0, 70000)); add_pct = 55; end
        5: begin en = 1'b0; lim = TOT_W'($urandom); add_pct = 25; end
        6: begin en = 1'b1; lim = TOT_W'($urandom_range(300000, 1048574)); add_pct = 70; end
        default: begin en = 1'b1; lim = 20'd1; add_pct = 45; end
      endcase
      set_policy(en, lim);
      if (ph == 0) begin
        // queue is full here: make room, then one add flushes every entry
        push_cmd(CMD_DEPART, '0, '0);
        push_cmd(CMD_ADD, ID_W'($urandom), WT_W'($urandom_range(1, 16'hFFFF)));
      end
      for (i = 0; i < ((ph == 0) ? PHASE_ITEMS - 2 : PHASE_ITEMS); i++)
        cmd_backlog.push_back(random_item(add_pct));
      if (ph < NUM_PHASES - 1) wait_quiet();
    end

    while (cmd_backlog.size() > 0 || start) @(posedge clk);
    drain = 0;
    while (expected_events.size() > 0 && drain < 40 * DEPTH) begin
      @(posedge clk);
      drain++;
    end
    repeat (DEPTH + 8) @(posedge clk);
    if (expected_events.size() > 0) begin
      $error("%0d predicted result words never arrived", expected_events.size());
      fail_count++;
    end

    $display("ran %0d commands under %0d policy settings, checked %0d result words",
             items_sent, NUM_PHASES + 1, words_checked);
    $display("auto-evicted %0d, full rejects %0d, empty departs %0d, finds %0d hit %0d miss",
             kind_seen[EV_AUTO_DEP], kind_seen[EV_FULL], kind_seen[EV_EMPTY],
             kind_seen[EV_FOUND], kind_seen[EV_NOT_FOUND]);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout: %0d predicted words still pending", expected_events.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ weighted_fifo_drop_oldest_unit.f @@
src/wfd_pkg.sv
src/wfd_cell.sv
src/weighted_fifo_drop_oldest_unit.sv
tb/tb_weighted_fifo_drop_oldest_unit.sv
